>>> hdl/array_list_engine_unit_defines.svh
`ifndef ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH
`define ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH

// Same-cycle check, disabled while reset is low.
`define ALE_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("array list engine check failed");

// Next-cycle check, disabled while reset is low.
`define ALE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("array list engine check failed");

`endif

>>> hdl/ale_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ale_pkg;

    localparam int MODE_W = 4;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 9;
    localparam int CNT_W  = 9;

    localparam int CAPACITY_DEF   = 256;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [CNT_W-1:0] CAP_LIMIT_RST = 9'd256;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FRONT = 4'd0,
        MODE_INS_BACK  = 4'd1,
        MODE_INS_AT    = 4'd2,
        MODE_REM_FRONT = 4'd3,
        MODE_REM_BACK  = 4'd4,
        MODE_REM_AT    = 4'd5,
        MODE_SEARCH    = 4'd6,
        MODE_SELECT    = 4'd7,
        MODE_REPLACE   = 4'd8
    } t_mode;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] read_value;
        logic [CNT_W-1:0] found_index;
        logic [CNT_W-1:0] count;
        logic             is_empty;
        logic             is_full;
    } t_rsp;

endpackage

`default_nettype wire

>>> hdl/ale_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ale_req_if
    import ale_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [VAL_W-1:0]  value;
    logic [POS_W-1:0]  position;

    modport source (output valid, output mode, output value, output position, input ready);
    modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface ale_rsp_if
    import ale_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             ok;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] found_index;
    logic [CNT_W-1:0] count;
    logic             is_empty;
    logic             is_full;

    modport source (output valid, output ok, output read_value, output found_index,
                    output count, output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input read_value, input found_index,
                    input count, input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

>>> hdl/ale_store.sv
`timescale 1ns / 1ps
`default_nettype none

module ale_store
    import ale_pkg::*;
#(
    parameter int DEPTH      = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [DATA_WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]         i_raddr,
    output logic      [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/array_list_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered array list engine. Entries live in a single store with one write and one
// registered read port; requests are handled one at a time and each yields exactly
// one response. Insert at position p walks the count - p entries above it, one
// read and one write per cycle; remove at p shifts the entries above p down the same
// way. Search reads one entry per cycle. Select reads one entry; replace, remove at
// the back, rejected and unknown requests go straight to the response. A finished
// response sits in an output register, so the next request is taken while it waits.
// The user must write the capacity limit register through i_cfg_wdata/i_cfg_we only
// while no request is in flight; the block itself does not enforce it. The store
// needs no clearing pass after reset.
module array_list_engine_unit
    import ale_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    ale_req_if.sink               i_req,
    ale_rsp_if.source             o_rsp
);

`include "array_list_engine_unit_defines.svh"

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int EW = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_SEARCH,
        S_SELECT,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_cap, n_cap;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic                  r_is_ins, n_is_ins;
    logic                  r_up, n_up;
    logic [CNT_W-1:0]      r_left, n_left;
    logic [CNT_W-1:0]      r_src, n_src;
    logic                  r_wpend, n_wpend;
    logic [CNT_W-1:0]      r_wa, n_wa;
    logic                  r_cmp_pend, n_cmp_pend;
    logic [CNT_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic                  r_ok, n_ok;
    logic [VAL_W-1:0]      r_rd, n_rd;
    logic [CNT_W-1:0]      r_fidx, n_fidx;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out, n_out;

    logic                  mem_we;
    logic [CNT_W-1:0]      mem_wa;
    logic [DATA_WIDTH-1:0] mem_wd;
    logic [CNT_W-1:0]      mem_ra;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic [CNT_W-1:0]      limit;
    logic                  full;
    logic [EW-1:0]         in_ext;
    logic [DATA_WIDTH-1:0] in_val;
    logic [EW-1:0]         rd_ext;
    logic [CNT_W-1:0]      sel_addr;
    logic [CNT_W-1:0]      ins_p;
    logic [CNT_W-1:0]      rem_p;

    ale_store #(
        .DEPTH      (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(mem_wa)),
        .i_wdata (mem_wd),
        .i_raddr (AW'(mem_ra)),
        .o_rdata (mem_rdata)
    );

    // Saturate the limit at the store depth.
    assign limit  = (32'(r_cap) > CAPACITY) ? CNT_W'(CAPACITY) : r_cap;
    assign full   = (r_count >= limit);
    assign in_ext = EW'(i_req.value);
    assign in_val = in_ext[DATA_WIDTH-1:0];
    assign rd_ext = EW'(mem_rdata);

    assign sel_addr = (CNT_W'(i_req.position) < r_count) ? CNT_W'(i_req.position)
                                                         : r_count - 1'b1;
    assign ins_p = (t_mode'(i_req.mode) == MODE_INS_FRONT) ? '0 :
                   (t_mode'(i_req.mode) == MODE_INS_BACK)  ? r_count :
                                                             CNT_W'(i_req.position);
    assign rem_p = (t_mode'(i_req.mode) == MODE_REM_FRONT) ? '0 : CNT_W'(i_req.position);

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_out.ok;
    assign o_rsp.read_value  = r_out.read_value;
    assign o_rsp.found_index = r_out.found_index;
    assign o_rsp.count       = r_out.count;
    assign o_rsp.is_empty    = r_out.is_empty;
    assign o_rsp.is_full     = r_out.is_full;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cap       = i_cfg_we ? i_cfg_wdata : r_cap;
        n_val       = r_val;
        n_pos       = r_pos;
        n_is_ins    = r_is_ins;
        n_up        = r_up;
        n_left      = r_left;
        n_src       = r_src;
        n_wpend     = 1'b0;
        n_wa        = r_wa;
        n_cmp_pend  = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_ok        = r_ok;
        n_rd        = r_rd;
        n_fidx      = r_fidx;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_wa      = r_wa;
        mem_wd      = mem_rdata;
        mem_ra      = r_src;

        case (r_state)
            S_IDLE: begin
                mem_ra = sel_addr;
                if (i_req.valid) begin
                    n_val    = in_val;
                    n_ok     = 1'b0;
                    n_rd     = '0;
                    n_fidx   = '0;
                    n_is_ins = 1'b0;
                    n_state  = S_DONE;
                    case (t_mode'(i_req.mode))
                        MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
                            if (!full && ins_p <= r_count) begin
                                n_ok     = 1'b1;
                                n_is_ins = 1'b1;
                                n_up     = 1'b0;
                                n_pos    = POS_W'(ins_p);
                                n_left   = r_count - ins_p;
                                n_src    = r_count - 1'b1;
                                n_count  = r_count + 1'b1;
                                n_state  = S_MOVE;
                            end
                        end
                        MODE_REM_FRONT, MODE_REM_AT: begin
                            if (rem_p < r_count) begin
                                n_ok    = 1'b1;
                                n_up    = 1'b1;
                                n_left  = r_count - 1'b1 - rem_p;
                                n_src   = rem_p + 1'b1;
                                n_count = r_count - 1'b1;
                                n_state = S_MOVE;
                            end
                        end
                        MODE_REM_BACK: begin
                            if (r_count != '0) begin
                                n_ok    = 1'b1;
                                n_count = r_count - 1'b1;
                            end
                        end
                        MODE_SEARCH: begin
                            n_fidx = r_count;
                            if (r_count != '0) begin
                                n_left  = r_count;
                                n_src   = '0;
                                n_state = S_SEARCH;
                            end
                        end
                        MODE_SELECT: begin
                            if (r_count != '0) begin
                                n_ok    = (CNT_W'(i_req.position) < r_count);
                                n_state = S_SELECT;
                            end
                        end
                        MODE_REPLACE: begin
                            if (CNT_W'(i_req.position) < r_count) begin
                                mem_we = 1'b1;
                                mem_wa = CNT_W'(i_req.position);
                                mem_wd = in_val;
                                n_ok   = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_MOVE: begin
                // Each read's data is written back in the following cycle, moving away from the gap.
                if (r_wpend) begin
                    mem_we = 1'b1;
                end
                if (r_left != '0) begin
                    n_left  = r_left - 1'b1;
                    n_src   = r_up ? r_src + 1'b1 : r_src - 1'b1;
                    n_wpend = 1'b1;
                    n_wa    = r_up ? r_src - 1'b1 : r_src + 1'b1;
                end else if (!r_wpend) begin
                    if (r_is_ins) begin
                        mem_we = 1'b1;
                        mem_wa = CNT_W'(r_pos);
                        mem_wd = r_val;
                    end
                    n_state = S_DONE;
                end
            end

            S_SEARCH: begin
                if (r_left != '0) begin
                    n_left     = r_left - 1'b1;
                    n_src      = r_src + 1'b1;
                    n_cmp_pend = 1'b1;
                    n_cmp_idx  = r_src;
                end
                if (r_cmp_pend && mem_rdata == r_val) begin
                    n_ok       = 1'b1;
                    n_fidx     = r_cmp_idx;
                    n_cmp_pend = 1'b0;
                    n_state    = S_DONE;
                end else if (r_left == '0 && !r_cmp_pend) begin
                    n_state = S_DONE;
                end
            end

            S_SELECT: begin
                n_rd    = rd_ext[VAL_W-1:0];
                n_state = S_DONE;
            end

            S_DONE: begin
                // Hold until the output register is free.
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid       = 1'b1;
                    n_out.ok          = r_ok;
                    n_out.read_value  = r_rd;
                    n_out.found_index = r_fidx;
                    n_out.count       = r_count;
                    n_out.is_empty    = (r_count == '0);
                    n_out.is_full     = full;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap       <= CAP_LIMIT_RST;
            r_wpend     <= 1'b0;
            r_cmp_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_wpend     <= n_wpend;
            r_cmp_pend  <= n_cmp_pend;
            r_out_valid <= n_out_valid;
        end
        r_val     <= n_val;
        r_pos     <= n_pos;
        r_is_ins  <= n_is_ins;
        r_up      <= n_up;
        r_left    <= n_left;
        r_src     <= n_src;
        r_wa      <= n_wa;
        r_cmp_idx <= n_cmp_idx;
        r_ok      <= n_ok;
        r_rd      <= n_rd;
        r_fidx    <= n_fidx;
        r_out     <= n_out;
    end

    `ALE_ASSERT(a_count_in_store, i_clk, i_rst_n, 1'b1, 32'(r_count) <= CAPACITY)
    `ALE_ASSERT(a_shift_write_in_list, i_clk, i_rst_n, r_state == S_MOVE && r_wpend, r_wa < r_count)
    `ALE_ASSERT_NEXT(a_request_leaves_idle, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state != S_IDLE)
    `ALE_ASSERT(a_response_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DONE)

endmodule

`default_nettype wire

>>> tb/sv/array_list_engine_unit_test.sv
`timescale 1ns / 1ps

module array_list_engine_unit_test;
    import ale_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd9;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;
    localparam int STUCK_LIMIT = 5000;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [VAL_W-1:0]  value;
        logic [POS_W-1:0]  position;
    } t_list_req;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    ale_req_if req_bus ();
    ale_rsp_if rsp_bus ();

    array_list_engine_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_bus.sink),
        .o_rsp       (rsp_bus.source)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow copy of the list and its limit
    logic [VAL_W-1:0] shadow_entries [CAPACITY_DEF];
    int               shadow_len = 0;
    logic [CNT_W-1:0] shadow_limit = CAP_LIMIT_RST;

    t_list_req pending_reqs [$];
    t_rsp      expected_rsps [$];

    int  fail_count   = 0;
    int  stuck_cycles = 0;
    int  gap_left     = 0;
    int  stall_left   = 0;
    int  send_quiet   = 0;
    int  recv_quiet   = 0;
    bit  req_taken    = 1'b0;

    function automatic t_rsp apply_list_request(logic [MODE_W-1:0] op,
                                                logic [VAL_W-1:0] val,
                                                logic [POS_W-1:0] pos);
        t_rsp r;
        int   lim;
        int   at;
        bit   ins;
        r   = '0;
        lim = (shadow_limit > CAPACITY_DEF) ? CAPACITY_DEF : int'(shadow_limit);
        ins = 1'b0;
        at  = int'(pos);
        case (op)
            MODE_INS_FRONT: begin
                ins = 1'b1;
                at  = 0;
            end
            MODE_INS_BACK: begin
                ins = 1'b1;
                at  = shadow_len;
            end
            MODE_INS_AT: ins = 1'b1;
            MODE_REM_FRONT, MODE_REM_AT: begin
                if (op == MODE_REM_FRONT)
                    at = 0;
                if (at < shadow_len) begin
                    for (int i = at; i + 1 < shadow_len; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_len--;
                    r.ok = 1'b1;
                end
            end
            MODE_REM_BACK: begin
                if (shadow_len > 0) begin
                    shadow_len--;
                    r.ok = 1'b1;
                end
            end
            MODE_SEARCH: begin
                r.found_index = CNT_W'(shadow_len);
                // walk downward so the lowest hit wins
                for (int i = shadow_len - 1; i >= 0; i--) begin
                    if (shadow_entries[i] == val) begin
                        r.found_index = CNT_W'(i);
                        r.ok          = 1'b1;
                    end
                end
            end
            MODE_SELECT: begin
                if (shadow_len > 0) begin
                    if (at < shadow_len) begin
                        r.read_value = shadow_entries[at];
                        r.ok         = 1'b1;
                    end else begin
                        r.read_value = shadow_entries[shadow_len - 1];
                    end
                end
            end
            MODE_REPLACE: begin
                if (at < shadow_len) begin
                    shadow_entries[at] = val;
                    r.ok               = 1'b1;
                end
            end
            default: ;
        endcase
        if (ins && shadow_len < lim && at <= shadow_len) begin
            for (int i = shadow_len; i > at; i--)
                shadow_entries[i] = shadow_entries[i - 1];
            shadow_entries[at] = val;
            shadow_len++;
            r.ok = 1'b1;
        end
        r.count    = CNT_W'(shadow_len);
        r.is_empty = (shadow_len == 0);
        r.is_full  = (shadow_len >= lim);
        return r;
    endfunction

    // mostly back-to-back, some short pauses, a few long ones, and quiet stretches
    function automatic int pick_pause(inout int quiet_left);
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            quiet_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_request(logic [MODE_W-1:0] op, logic [VAL_W-1:0] val,
                                 logic [POS_W-1:0] pos);
        t_list_req item;
        item.mode     = op;
        item.value    = val;
        item.position = pos;
        pending_reqs.push_back(item);
    endtask

    task automatic queue_random_requests(int n, int span, bit fill);
        int               r;
        logic [MODE_W-1:0] op;
        logic [VAL_W-1:0]  val;
        logic [POS_W-1:0]  pos;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (fill && $urandom_range(0, 99) < 70) op = MODE_INS_BACK;
            else if (r < 12) op = MODE_INS_FRONT;
            else if (r < 24) op = MODE_INS_BACK;
            else if (r < 36) op = MODE_INS_AT;
            else if (r < 46) op = MODE_REM_FRONT;
            else if (r < 56) op = MODE_REM_BACK;
            else if (r < 68) op = MODE_REM_AT;
            else if (r < 78) op = MODE_SEARCH;
            else if (r < 88) op = MODE_SELECT;
            else if (r < 96) op = MODE_REPLACE;
            else op = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            // a small value pool keeps search hits frequent
            r = $urandom_range(0, 99);
            if (r < 50) val = VAL_W'($urandom_range(0, 7));
            else if (r < 55) val = '1;
            else val = VAL_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < 70) pos = POS_W'($urandom_range(0, span));
            else if (r < 85) pos = POS_W'($urandom_range(0, CAPACITY_DEF));
            else pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
            queue_request(op, val, pos);
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_bus.valid || expected_rsps.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_capacity(logic [CNT_W-1:0] lim);
        @(negedge clk);
        cfg_we       = 1'b1;
        cfg_wdata    = lim;
        shadow_limit = lim;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic run_phase(logic [CNT_W-1:0] lim, int n, int span, bit fill);
        wait_drained();
        set_capacity(lim);
        queue_random_requests(n, span, fill);
    endtask

    // request side: hold until accepted, then pause or present the next one
    always @(negedge clk) begin
        if (!rst_n) begin
            req_bus.valid <= 1'b0;
        end else if (!req_bus.valid || req_taken) begin
            if (gap_left > 0) begin
                req_bus.valid <= 1'b0;
                gap_left      <= gap_left - 1;
            end else if (pending_reqs.size() > 0) begin
                req_bus.valid    <= 1'b1;
                req_bus.mode     <= pending_reqs[0].mode;
                req_bus.value    <= pending_reqs[0].value;
                req_bus.position <= pending_reqs[0].position;
                pending_reqs.delete(0);
                gap_left <= pick_pause(send_quiet);
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            rsp_bus.ready <= 1'b1;
            stall_left    <= pick_pause(recv_quiet);
        end
    end

    always @(posedge clk) begin : watch_list
        t_rsp want;
        t_rsp got;
        if (!rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_bus.valid && req_bus.ready;
            if (rsp_bus.valid && rsp_bus.ready) begin
                got = {rsp_bus.ok, rsp_bus.read_value, rsp_bus.found_index,
                       rsp_bus.count, rsp_bus.is_empty, rsp_bus.is_full};
                if (expected_rsps.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: result with no request outstanding: %p", $realtime, got);
                end else begin
                    want = expected_rsps.pop_front();
                    if (got.ok !== want.ok || got.read_value !== want.read_value ||
                        got.found_index !== want.found_index || got.count !== want.count ||
                        got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display({"%0t: mismatch exp ok=%0d rd=%h idx=%0d cnt=%0d e=%0d f=%0d",
                                      " got ok=%0d rd=%h idx=%0d cnt=%0d e=%0d f=%0d"}, $realtime,
                                     want.ok, want.read_value, want.found_index, want.count,
                                     want.is_empty, want.is_full, got.ok, got.read_value,
                                     got.found_index, got.count, got.is_empty, got.is_full);
                    end
                end
            end
            if (req_bus.valid && req_bus.ready)
                expected_rsps.push_back(apply_list_request(req_bus.mode, req_bus.value,
                                                           req_bus.position));
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("array_list_engine_unit_test NOT OK");
                    $finish;
                end
            end
        end
    end

    initial begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        req_bus.valid    = 1'b0;
        req_bus.mode     = '0;
        req_bus.value    = '0;
        req_bus.position = '0;
        rsp_bus.ready    = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_capacity(CAP_LIMIT_RST);
        // empty list: every read or removal is rejected
        queue_request(MODE_SELECT, '0, '0);
        queue_request(MODE_REM_FRONT, '0, '0);
        queue_request(MODE_REM_BACK, '0, '0);
        queue_request(MODE_REM_AT, '0, '0);
        queue_request(MODE_SEARCH, '0, '0);
        queue_request(MODE_REPLACE, 32'h1, '0);
        queue_request(MODE_UNUSED_HI, '1, '1);
        queue_request(MODE_INS_AT, 32'h2, 9'd1);
        // build a short list and probe it
        queue_request(MODE_INS_FRONT, '0, '1);
        queue_request(MODE_INS_BACK, '1, '0);
        queue_request(MODE_INS_AT, 32'hA5A5_A5A5, 9'd1);
        queue_request(MODE_INS_AT, 32'h5A5A_5A5A, 9'd3);
        queue_request(MODE_SEARCH, '1, '0);
        queue_request(MODE_SEARCH, 32'h1234_5678, '0);
        queue_request(MODE_SELECT, '0, 9'd1);
        queue_request(MODE_SELECT, '0, 9'd256);
        queue_request(MODE_SELECT, '0, '1);
        queue_request(MODE_REPLACE, 32'h1357_9BDF, 9'd0);
        queue_request(MODE_REPLACE, 32'h3, 9'd4);
        queue_request(MODE_REM_AT, '0, 9'd4);
        queue_request(MODE_REM_AT, '0, 9'd1);
        queue_request(MODE_REM_FRONT, '0, '0);
        queue_request(MODE_REM_BACK, '0, '0);
        queue_request(MODE_UNUSED_LO, 32'h4, 9'd2);
        queue_request(MODE_REM_AT, '0, 9'd0);

        run_phase(9'd0, 20, 8, 1'b0);
        run_phase(9'd8, 150, 9, 1'b0);
        // drop the limit under the current count
        run_phase(9'd3, 60, 10, 1'b0);
        // saturating limit; fill to the full store
        run_phase(9'd511, 270, 260, 1'b1);
        run_phase(9'd1, 40, 260, 1'b0);
        run_phase(CAP_LIMIT_RST, 150, 64, 1'b0);

        wait_drained();
        repeat (20) @(posedge clk);
        fail_count += expected_rsps.size();
        if (fail_count == 0) begin
            $display("array_list_engine_unit_test OK");
        end else begin
            $display("array_list_engine_unit_test NOT OK");
        end
        $finish;
    end

endmodule
